// ===== rtl/ddn_pkg.sv =====
`default_nettype none

package ddn_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_COUNT_TIME     = 3'd0,
        REG_DEAD_TIME      = 3'd1,
        REG_MONITOR_DARK   = 3'd2,
        REG_DETECTOR_DARK  = 3'd3,
        REG_REFERENCE      = 3'd4
    } cfg_idx_t;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // fixed-point constants
    localparam logic [47:0] SMALL_LIMIT = 48'd655;
    localparam logic [47:0] ONE_Q16     = 48'd65536;
    localparam logic [47:0] POS_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_MAX     = 48'h8000_0000_0000;
    localparam logic [47:0] VAR_MAX     = 48'hFFFF_FFFF_FFFF;

    localparam logic [31:0] COUNT_TIME_RST = 32'd65536;
    localparam logic [31:0] REFERENCE_RST  = 32'd65536;

endpackage

`default_nettype wire

// ===== rtl/ddn_div.sv =====
`default_nettype none

module ddn_div #(
    parameter int DW = 32,
    parameter int QW = 48,
    parameter int SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [QW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QW-1:0]      out_quo,
    output logic [SW-1:0]      out_side
);

    // one quotient bit per stage
    logic          v_reg    [1:QW];
    logic [QW-1:0] quo_reg  [1:QW];
    logic [SW-1:0] side_reg [1:QW];
    logic [DW-1:0] rem_reg  [1:QW-1];
    logic [QW-1:0] num_reg  [1:QW-1];
    logic [DW-1:0] den_reg  [1:QW-1];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_stage
            logic          v_cur;
            logic [QW-1:0] quo_cur;
            logic [SW-1:0] side_cur;
            logic [DW-1:0] rem_cur;
            logic [QW-1:0] num_cur;
            logic [DW-1:0] den_cur;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;

            if (i == 0) begin : g_first
                assign v_cur    = in_valid;
                assign quo_cur  = '0;
                assign side_cur = in_side;
                assign rem_cur  = in_rem;
                assign num_cur  = in_num;
                assign den_cur  = in_den;
            end
            else begin : g_next
                assign v_cur    = v_reg[i];
                assign quo_cur  = quo_reg[i];
                assign side_cur = side_reg[i];
                assign rem_cur  = rem_reg[i];
                assign num_cur  = num_reg[i];
                assign den_cur  = den_reg[i];
            end

            // shift in next numerator bit, subtract when it fits
            assign trial = {rem_cur, num_cur[QW-1]};
            assign ge    = trial >= {1'b0, den_cur};
            assign diff  = trial - {1'b0, den_cur};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i+1] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[i+1]  <= {quo_cur[QW-2:0], ge};
                    side_reg[i+1] <= side_cur;
                end
            end

            if (i < QW - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                        num_reg[i+1] <= {num_cur[QW-2:0], 1'b0};
                        den_reg[i+1] <= den_cur;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW];
    assign out_quo   = quo_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

`default_nettype wire

// ===== rtl/detector_deadtime_normalizer_top.sv =====
// stages in order: 1-3, variance divider, v1-v4, rate divider, n1-n5, intensity divider, output
// throughput: one item per cycle while the output is not stalled; three 1-bit-per-stage divider
//   pipelines (48, 56 and 48 stages) set the depth
// the whole pipeline holds while the output item is stalled
// reset: async active low, clears valid bits and loads register defaults
`default_nettype none

module detector_deadtime_normalizer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [23:0] raw_count,
    input  wire logic [31:0] monitor_reading,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [47:0]      corrected_count,
    output logic [47:0]      variance,
    output logic [1:0]       status
);

    import ddn_pkg::*;

    typedef struct packed {
        logic [23:0] y;
        logic        bad;
        logic        ovf;
        logic [31:0] m;
        logic [31:0] den;
    } side_q2_t;

    typedef struct packed {
        logic        bad;
        logic [31:0] m;
        logic [47:0] var_q;
        logic        satv;
    } side_rc_t;

    typedef struct packed {
        logic        bad;
        logic        neg;
        logic        ovf;
        logic [47:0] var_q;
        logic        satv;
    } side_q1_t;

    logic en;

    // configuration registers
    logic [31:0] count_time_reg;
    logic [31:0] dead_time_reg;
    logic [31:0] monitor_dark_reg;
    logic [31:0] detector_dark_reg;
    logic [31:0] reference_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_time_reg    <= COUNT_TIME_RST;
            dead_time_reg     <= '0;
            monitor_dark_reg  <= '0;
            detector_dark_reg <= '0;
            reference_reg     <= REFERENCE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_COUNT_TIME:    count_time_reg    <= cfg_data;
                REG_DEAD_TIME:     dead_time_reg     <= cfg_data;
                REG_MONITOR_DARK:  monitor_dark_reg  <= cfg_data;
                REG_DETECTOR_DARK: detector_dark_reg <= cfg_data;
                REG_REFERENCE:     reference_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // global advance: hold everything while the result waits
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // stage 1: monitor difference, tau * y
    logic        v1_reg;
    logic [23:0] y1_reg;
    logic [33:0] m1_reg;
    logic [39:0] e1_reg;
    logic [55:0] tau_y;

    assign tau_y = {24'b0, dead_time_reg} * {32'b0, raw_count};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg <= raw_count;
            m1_reg <= {{2{monitor_reading[31]}}, monitor_reading}
                    - {{2{monitor_dark_reg[31]}}, monitor_dark_reg};
            e1_reg <= tau_y[55:16];
        end
    end

    // stage 2: denominator, divisor checks, T * C
    logic        v2_reg;
    logic [23:0] y2_reg;
    logic        bad2_reg;
    logic [31:0] m2_reg;
    logic [31:0] den2_reg;
    logic [62:0] tc2_reg;
    logic [40:0] den_s;
    logic        bad_next;

    assign den_s    = {9'b0, count_time_reg} - {1'b0, e1_reg};
    assign bad_next = (count_time_reg == '0) || reference_reg[31] || (reference_reg == '0)
                    || m1_reg[33] || (m1_reg == '0) || den_s[40] || (den_s == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y2_reg   <= y1_reg;
            bad2_reg <= bad_next;
            m2_reg   <= m1_reg[31:0];
            den2_reg <= den_s[31:0];
            tc2_reg  <= {31'b0, count_time_reg} * {32'b0, reference_reg[30:0]};
        end
    end

    // stage 3: M * den
    logic        v3_reg;
    logic [23:0] y3_reg;
    logic        bad3_reg;
    logic [31:0] m3_reg;
    logic [31:0] den3_reg;
    logic [62:0] tc3_reg;
    logic [63:0] dv2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y3_reg   <= y2_reg;
            bad3_reg <= bad2_reg;
            m3_reg   <= m2_reg;
            den3_reg <= den2_reg;
            tc3_reg  <= tc2_reg;
            dv2_reg  <= {32'b0, m2_reg} * {32'b0, den2_reg};
        end
    end

    // variance ratio q = (T*C << 32) / (M * den)
    side_q2_t    sq2_in;
    side_q2_t    sq2_out;
    logic        vq2;
    logic [47:0] q2;

    assign sq2_in.y   = y3_reg;
    assign sq2_in.bad = bad3_reg;
    assign sq2_in.ovf = {17'b0, tc3_reg[62:16]} >= dv2_reg;
    assign sq2_in.m   = m3_reg;
    assign sq2_in.den = den3_reg;

    ddn_div #(.DW(64), .QW(48), .SW($bits(side_q2_t))) u_div_var (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rem    ({17'b0, tc3_reg[62:16]}),
        .in_num    ({tc3_reg[15:0], 32'b0}),
        .in_den    (dv2_reg),
        .in_side   (sq2_in),
        .out_valid (vq2),
        .out_quo   (q2),
        .out_side  (sq2_out)
    );

    // v1: partial squares of q
    logic        vv1_reg;
    side_q2_t    sv1_reg;
    logic [47:0] hh_reg;
    logic [47:0] hl_reg;
    logic [47:0] ll_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv1_reg <= sq2_out;
            hh_reg  <= {24'b0, q2[47:24]} * {24'b0, q2[47:24]};
            hl_reg  <= {24'b0, q2[47:24]} * {24'b0, q2[23:0]};
            ll_reg  <= {24'b0, q2[23:0]} * {24'b0, q2[23:0]};
        end
    end

    // v2: q squared
    logic        vv2_reg;
    side_q2_t    sv2_reg;
    logic [95:0] sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv2_reg <= sv1_reg;
            sq_reg  <= {hh_reg, 48'b0} + {23'b0, hl_reg, 25'b0} + {48'b0, ll_reg};
        end
    end

    // v3: partial products of y * q^2
    logic        vv3_reg;
    side_q2_t    sv3_reg;
    logic [55:0] a0_reg;
    logic [55:0] a1_reg;
    logic [55:0] a2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv3_reg <= sv2_reg;
            a0_reg  <= {32'b0, sv2_reg.y} * {24'b0, sq_reg[31:0]};
            a1_reg  <= {32'b0, sv2_reg.y} * {24'b0, sq_reg[63:32]};
            a2_reg  <= {32'b0, sv2_reg.y} * {24'b0, sq_reg[95:64]};
        end
    end

    // v4: variance with saturation
    logic         vv4_reg;
    logic [23:0]  y4_reg;
    logic         bad4_reg;
    logic [31:0]  m4_reg;
    logic [31:0]  den4_reg;
    logic [47:0]  var4_reg;
    logic         satv4_reg;
    logic [119:0] yp;
    logic [47:0]  var_next;
    logic         satv_next;

    assign yp = {64'b0, a0_reg} + {32'b0, a1_reg, 32'b0} + {a2_reg, 64'b0};

    always_comb
    begin
        if (sv3_reg.y == '0)
        begin
            var_next  = '0;
            satv_next = 1'b0;
        end
        else if (sv3_reg.ovf || (yp[119:96] != '0))
        begin
            var_next  = VAR_MAX;
            satv_next = 1'b1;
        end
        else
        begin
            var_next  = yp[95:48];
            satv_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y4_reg    <= sv3_reg.y;
            bad4_reg  <= sv3_reg.bad;
            m4_reg    <= sv3_reg.m;
            den4_reg  <= sv3_reg.den;
            var4_reg  <= var_next;
            satv4_reg <= satv_next;
        end
    end

    // corrected rate rc = (y << 32) / den
    side_rc_t    src_in;
    side_rc_t    src_out;
    logic        vrc;
    logic [55:0] rc;

    assign src_in.bad   = bad4_reg;
    assign src_in.m     = m4_reg;
    assign src_in.var_q = var4_reg;
    assign src_in.satv  = satv4_reg;

    ddn_div #(.DW(32), .QW(56), .SW($bits(side_rc_t))) u_div_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vv4_reg),
        .in_rem    ('0),
        .in_num    ({y4_reg, 32'b0}),
        .in_den    (den4_reg),
        .in_side   (src_in),
        .out_valid (vrc),
        .out_quo   (rc),
        .out_side  (src_out)
    );

    // n1: dark subtraction, sign and magnitude
    logic        vn1_reg;
    side_rc_t    sn1_reg;
    logic        neg1_reg;
    logic [56:0] mag1_reg;
    logic [57:0] net;
    logic [57:0] net_abs;

    assign net     = {2'b0, rc} - {{26{detector_dark_reg[31]}}, detector_dark_reg};
    assign net_abs = net[57] ? (58'd0 - net) : net;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn1_reg  <= src_out;
            neg1_reg <= net[57];
            mag1_reg <= net_abs[56:0];
        end
    end

    // n2: partial products of T * |net|
    logic        vn2_reg;
    side_rc_t    sn2_reg;
    logic        neg2_reg;
    logic [63:0] pa_reg;
    logic [56:0] pb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn2_reg  <= sn1_reg;
            neg2_reg <= neg1_reg;
            pa_reg   <= {32'b0, count_time_reg} * {32'b0, mag1_reg[31:0]};
            pb_reg   <= {25'b0, count_time_reg} * {32'b0, mag1_reg[56:32]};
        end
    end

    // n3: T * |net|
    logic        vn3_reg;
    side_rc_t    sn3_reg;
    logic        neg3_reg;
    logic [88:0] tm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn3_reg  <= sn2_reg;
            neg3_reg <= neg2_reg;
            tm_reg   <= {25'b0, pa_reg} + {pb_reg, 32'b0};
        end
    end

    // n4: partial products with reference current
    logic        vn4_reg;
    side_rc_t    sn4_reg;
    logic        neg4_reg;
    logic [62:0] b0_reg;
    logic [62:0] b1_reg;
    logic [55:0] b2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn4_reg  <= sn3_reg;
            neg4_reg <= neg3_reg;
            b0_reg   <= {31'b0, tm_reg[31:0]} * {32'b0, reference_reg[30:0]};
            b1_reg   <= {31'b0, tm_reg[63:32]} * {32'b0, reference_reg[30:0]};
            b2_reg   <= {31'b0, tm_reg[88:64]} * {25'b0, reference_reg[30:0]};
        end
    end

    // n5: full numerator
    logic         vn5_reg;
    side_rc_t     sn5_reg;
    logic         neg5_reg;
    logic [119:0] num1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn5_reg  <= sn4_reg;
            neg5_reg <= neg4_reg;
            num1_reg <= {57'b0, b0_reg} + {25'b0, b1_reg, 32'b0} + {b2_reg, 64'b0};
        end
    end

    // intensity q = num / (M << 16)
    side_q1_t    sq1_in;
    side_q1_t    sq1_out;
    logic        vq1;
    logic [47:0] q1;
    logic [47:0] dv1;

    assign dv1          = {sn5_reg.m, 16'b0};
    assign sq1_in.bad   = sn5_reg.bad;
    assign sq1_in.neg   = neg5_reg;
    assign sq1_in.ovf   = num1_reg[119:48] >= {24'b0, dv1};
    assign sq1_in.var_q = sn5_reg.var_q;
    assign sq1_in.satv  = sn5_reg.satv;

    ddn_div #(.DW(48), .QW(48), .SW($bits(side_q1_t))) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vn5_reg),
        .in_rem    (num1_reg[95:48]),
        .in_num    (num1_reg[47:0]),
        .in_den    (dv1),
        .in_side   (sq1_in),
        .out_valid (vq1),
        .out_quo   (q1),
        .out_side  (sq1_out)
    );

    // output stage: saturation, small-value replacement, status
    logic        out_v_reg;
    logic [47:0] res_reg;
    logic [47:0] var_reg;
    logic [1:0]  status_reg;
    logic [47:0] res_next;
    logic        sat1;

    always_comb
    begin
        sat1 = sq1_out.ovf || (q1 > (sq1_out.neg ? NEG_MAX : POS_MAX));
        if (sat1)
        begin
            res_next = sq1_out.neg ? NEG_MAX : POS_MAX;
        end
        else if (q1 <= SMALL_LIMIT)
        begin
            res_next = ONE_Q16;
        end
        else
        begin
            res_next = sq1_out.neg ? (48'd0 - q1) : q1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sq1_out.bad)
            begin
                res_reg    <= '0;
                var_reg    <= '0;
                status_reg <= ST_DIV;
            end
            else
            begin
                res_reg    <= res_next;
                var_reg    <= sq1_out.var_q;
                status_reg <= (sat1 || sq1_out.satv) ? ST_SAT : ST_OK;
            end
        end
    end

    // valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            vv1_reg   <= 1'b0;
            vv2_reg   <= 1'b0;
            vv3_reg   <= 1'b0;
            vv4_reg   <= 1'b0;
            vn1_reg   <= 1'b0;
            vn2_reg   <= 1'b0;
            vn3_reg   <= 1'b0;
            vn4_reg   <= 1'b0;
            vn5_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vv1_reg   <= vq2;
            vv2_reg   <= vv1_reg;
            vv3_reg   <= vv2_reg;
            vv4_reg   <= vv3_reg;
            vn1_reg   <= vrc;
            vn2_reg   <= vn1_reg;
            vn3_reg   <= vn2_reg;
            vn4_reg   <= vn3_reg;
            vn5_reg   <= vn4_reg;
            out_v_reg <= vq1;
        end
    end

    assign out_valid       = out_v_reg;
    assign corrected_count = res_reg;
    assign variance        = var_reg;
    assign status          = status_reg;

endmodule

`default_nettype wire

// ===== rtl/ddn_checker.sv =====
`default_nettype none

module ddn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [47:0] corrected_count,
    input wire logic [47:0] variance,
    input wire logic [1:0]  status
);

    import ddn_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(corrected_count)
        && $stable(variance) && $stable(status))
        else $error("stalled output item changed");

    // input is held back only by a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a bad divisor gives zero results
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DIV) |-> (corrected_count == '0) && (variance == '0))
        else $error("divisor error with nonzero result");

    // a good result is never zero, small values become one
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DIV) |-> corrected_count != '0)
        else $error("zero intensity on a valid point");

    // no undefined status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_DIV) || (status == ST_SAT))
        else $error("undefined status code");

endmodule

bind detector_deadtime_normalizer_top ddn_checker u_ddn_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .corrected_count (corrected_count),
    .variance        (variance),
    .status          (status)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ddn_pkg::*;

    // register indexes the block has no register for
    localparam logic [2:0] IDX_SPARE_LO = 3'd5;
    localparam logic [2:0] IDX_SPARE_HI = 3'd7;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [47:0] intensity;
        logic [47:0] spread;
        logic [1:0]  code;
    } point_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [23:0] raw_count = 24'd0;
    logic [31:0] monitor_reading = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [47:0] corrected_count;
    logic [47:0] variance;
    logic [1:0]  status;

    // shadow copy of the configuration registers
    logic [31:0] count_time_r = COUNT_TIME_RST;
    logic [31:0] dead_time_r = 32'd0;
    logic [31:0] mon_dark_r = 32'd0;
    logic [31:0] det_dark_r = 32'd0;
    logic [31:0] ref_cur_r = REFERENCE_RST;

    point_t expected_points[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    detector_deadtime_normalizer_top uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // dead-time corrected, normalized intensity and variance of one point
    function automatic point_t normalize_point(logic [23:0] y, logic [31:0] mr);
        point_t pt;
        logic signed [33:0] mon;
        logic [63:0] e, rc, mag, den_u;
        logic signed [63:0] den, net;
        logic [127:0] num, q, a, q2, p, lim;
        logic neg, sat;
        pt = '{intensity: 48'd0, spread: 48'd0, code: ST_DIV};
        sat = 1'b0;
        mon = $signed({{2{mr[31]}}, mr}) - $signed({{2{mon_dark_r[31]}}, mon_dark_r});
        if (count_time_r == 0 || $signed(ref_cur_r) <= 0 || mon <= 0)
            return pt;
        e = (64'(dead_time_r) * 64'(y)) >> 16;
        den = $signed(64'(count_time_r)) - $signed(e);
        if (den <= 0)
            return pt;
        den_u = den;
        rc = (64'(y) << 32) / den_u;
        net = $signed(rc) - $signed({{32{det_dark_r[31]}}, det_dark_r});
        neg = net < 0;
        mag = neg ? -net : net;
        num = 128'(count_time_r) * 128'(mag) * 128'(ref_cur_r);
        q = num / (128'(mon[32:0]) * 128'd65536);
        lim = neg ? 128'(NEG_MAX) : 128'(POS_MAX);
        if (q > lim)
        begin
            sat = 1'b1;
            pt.intensity = neg ? NEG_MAX : POS_MAX;
        end
        else if (q <= 128'(SMALL_LIMIT))
            pt.intensity = ONE_Q16;
        else
            pt.intensity = neg ? -q[47:0] : q[47:0];
        a = (128'(count_time_r) * 128'(ref_cur_r)) << 32;
        q2 = a / (128'(mon[32:0]) * 128'(den_u));
        if (y == 0)
            pt.spread = 48'd0;
        else if (q2 > 128'(VAR_MAX))
        begin
            sat = 1'b1;
            pt.spread = VAR_MAX;
        end
        else
        begin
            p = (q2 * q2 * 128'(y)) >> 48;
            if (p > 128'(VAR_MAX))
            begin
                sat = 1'b1;
                pt.spread = VAR_MAX;
            end
            else
                pt.spread = p[47:0];
        end
        pt.code = sat ? ST_SAT : ST_OK;
        return pt;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
                report_mismatch("unexpected item", corrected_count, 48'd0);
            else
            begin
                want = expected_points.pop_front();
                if (corrected_count !== want.intensity)
                    report_mismatch("corrected_count", corrected_count, want.intensity);
                if (variance !== want.spread)
                    report_mismatch("variance", variance, want.spread);
                if (status !== want.code)
                    report_mismatch("status", 48'(status), 48'(want.code));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // send one item, leaves valid high on return
    task automatic send_point(logic [23:0] y, logic [31:0] mr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_count <= y;
        monitor_reading <= mr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_points.push_back(normalize_point(y, mr));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_COUNT_TIME:    count_time_r = val;
            REG_DEAD_TIME:     dead_time_r = val;
            REG_MONITOR_DARK:  mon_dark_r = val;
            REG_DETECTOR_DARK: det_dark_r = val;
            REG_REFERENCE:     ref_cur_r = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] ct, logic [31:0] dt, logic [31:0] md,
                              logic [31:0] dd, logic [31:0] rc);
        write_reg(REG_COUNT_TIME, ct);
        write_reg(REG_DEAD_TIME, dt);
        write_reg(REG_MONITOR_DARK, md);
        write_reg(REG_DETECTOR_DARK, dd);
        write_reg(REG_REFERENCE, rc);
        cfg_valid <= 1'b0;
    endtask

    // reset defaults: field extremes, monitor at or below dark, small results
    task automatic test_default_config;
        send_point(24'd0, 32'h0001_0000);
        send_point(24'hFF_FFFF, 32'h0001_0000);
        send_point(24'd1, 32'h0001_0000);
        send_point(24'd100, 32'h7FFF_FFFF);
        send_point(24'd1, 32'h8000_0000);
        send_point(24'd5, 32'd0);
        send_point(24'hFF_FFFF, 32'd1);
        send_point(24'd3, 32'hFFFF_FFFF);
        drain();
    endtask

    // zero count time, nonpositive reference, dead time eating the count time
    task automatic test_bad_divisors;
        set_config(32'd0, 32'd0, 32'd0, 32'd0, REFERENCE_RST);
        send_point(24'd10, 32'h0001_0000);
        drain();
        set_config(COUNT_TIME_RST, 32'd0, 32'd0, 32'd0, 32'd0);
        send_point(24'd10, 32'h0001_0000);
        drain();
        set_config(COUNT_TIME_RST, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
        send_point(24'd10, 32'h0001_0000);
        drain();
        set_config(COUNT_TIME_RST, 32'hFFFF_FFFF, 32'd0, 32'd0, REFERENCE_RST);
        send_point(24'd1, 32'h0001_0000);
        send_point(24'hFF_FFFF, 32'h0001_0000);
        drain();
    endtask

    // dark subtraction driving large, negative and saturated results
    task automatic test_saturation;
        set_config(32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(24'd0, 32'h8000_0001);
        send_point(24'hFF_FFFF, 32'h8000_0001);
        send_point(24'd1, 32'h7FFF_FFFF);
        drain();
        set_config(32'd1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, REFERENCE_RST);
        send_point(24'd2, 32'h7FFF_FFFF);
        drain();
        // writes to unmapped indexes must change nothing
        write_reg(IDX_SPARE_LO, 32'hDEAD_BEEF);
        write_reg(IDX_SPARE_HI, 32'h0000_0001);
        cfg_valid <= 1'b0;
        send_point(24'd50, 32'h7FFF_FFFF);
        send_point(24'd50, 32'h7FFF_0000);
        drain();
    endtask

    function automatic logic [31:0] pick32(logic [31:0] lo, logic [31:0] hi, logic [31:0] typ);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return typ;
            default: return $urandom;
        endcase
    endfunction

    task automatic randomize_config;
        set_config(pick32(32'd1, 32'hFFFF_FFFF, 32'h0001_0000 * $urandom_range(1, 100)),
                   ($urandom_range(3) == 0) ? pick32(32'd0, 32'hFFFF_FFFF, 32'd0)
                                            : $urandom_range(0, 4000),
                   pick32(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(0, 32'h0010_0000)),
                   pick32(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(0, 32'h0100_0000)),
                   pick32(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000 * $urandom_range(1, 50)));
    endtask

    // mostly monitor above dark level, counts modest half the time, some raw noise
    task automatic send_random_point;
        logic [23:0] y;
        logic [31:0] mr;
        y = ($urandom_range(1) == 0) ? 24'($urandom_range(0, 4095)) : 24'($urandom);
        if ($urandom_range(9) < 7)
            mr = mon_dark_r + $urandom_range(1, 32'h00FF_FFFF);
        else
            mr = $urandom;
        send_point(y, mr);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_p);
        send_idle_pct = idle_pct;
        stall_pct = stall_p;
        repeat (3)
        begin
            randomize_config();
            repeat (84) send_random_point();
            drain();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_bad_divisors();
        test_saturation();
        test_random_traffic(37, 88);
        test_random_traffic(88, 37);
        test_random_traffic(0, 0);
        if (error_count == 0)
            $display("detector_deadtime_normalizer_top verification clean");
        else
            $display("detector_deadtime_normalizer_top verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("detector_deadtime_normalizer_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ddn_pkg.sv
rtl/ddn_div.sv
rtl/detector_deadtime_normalizer_top.sv
rtl/ddn_checker.sv
verif/testbench.sv
